// File: src/prefix_table_insert_lookup_top_assert.svh
// Assertion macros for the prefix table block and its checker.
// Each macro expands to one labelled concurrent assertion clocked on clk, reset on rst_n.
`ifndef PREFIX_TABLE_INSERT_LOOKUP_TOP_ASSERT_SVH
`define PREFIX_TABLE_INSERT_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define PTIL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds
`define PTIL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ptil_pkg.sv
// Shared types and constants for the prefix table block.
// Used by ptil_cell and prefix_table_insert_lookup_top; no dependencies.
package ptil_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // option byte that means "keep" on update and marks a fresh entry
    localparam logic [7:0] OPT_KEEP = 8'hff;

    localparam int PFX_BITS = 128;
    localparam int SLOT_W   = 8;   // covers up to 256 slots
    localparam int COUNT_W  = 9;   // holds 0 .. 256

    typedef logic [SLOT_W-1:0]  ptil_slot_t;
    typedef logic [COUNT_W-1:0] ptil_count_t;

    // Request token handed from cell to cell along the chain
    typedef struct packed {
        logic        valid;
        logic [1:0]  req;
        logic [63:0] pfx_hi;
        logic [63:0] pfx_lo;
        logic [7:0]  len;
        logic [31:0] vlife;
        logic [31:0] plife;
        logic [7:0]  flags;
        logic        found;
        logic        created;
        ptil_slot_t  at;
        logic [7:0]  opt;
        logic [31:0] ent_vl;
        logic [31:0] ent_pl;
    } ptil_tok_t;

    // Result as presented on the output channel
    typedef struct packed {
        logic        hit;
        logic        created;
        logic        full;
        logic [3:0]  idx;
        logic [7:0]  opt;
        logic [31:0] vl;
        logic [31:0] pl;
    } ptil_res_t;

endpackage

// File: src/ptil_cell.sv
// One slot of the prefix table: holds an entry and serves the request token passing by.
// Depends on ptil_pkg.
module ptil_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ptil_pkg::ptil_count_t count,
    input  ptil_pkg::ptil_tok_t tok_in,
    output ptil_pkg::ptil_tok_t tok_out
);
    import ptil_pkg::*;

    logic [63:0] pfx_hi_reg;
    logic [63:0] pfx_lo_reg;
    logic [7:0]  len_reg;
    logic [7:0]  opt_reg;
    logic [31:0] vl_reg;
    logic [31:0] pl_reg;

    ptil_tok_t tok_reg;
    ptil_tok_t tok_next;

    logic occupied;
    logic is_add;
    logic is_lookup;
    logic active;
    logic match;
    logic do_hit;
    logic do_upd;
    logic do_new;

    // Decide what this slot does with the passing request
    always_comb
    begin
        occupied  = ptil_count_t'(IDX) < count;
        is_add    = tok_in.req == REQ_ADD;
        is_lookup = tok_in.req == REQ_LOOKUP;
        active    = tok_in.valid && (is_add || is_lookup) && !tok_in.found && !tok_in.created;
        match     = occupied && (len_reg == tok_in.len) && (pfx_hi_reg == tok_in.pfx_hi)
                    && (pfx_lo_reg == tok_in.pfx_lo);
        do_hit    = active && match;
        do_upd    = do_hit && is_add && (tok_in.flags != OPT_KEEP);
        // first free slot: every earlier slot has already missed
        do_new    = active && is_add && !occupied && (ptil_count_t'(IDX) == count);
    end

    // Fill in the token with this slot's answer
    always_comb
    begin
        tok_next = tok_in;
        if (do_hit)
        begin
            tok_next.found  = 1'b1;
            tok_next.at     = ptil_slot_t'(IDX);
            tok_next.opt    = do_upd ? tok_in.flags : opt_reg;
            tok_next.ent_vl = do_upd ? tok_in.vlife : vl_reg;
            tok_next.ent_pl = do_upd ? tok_in.plife : pl_reg;
        end
        else if (do_new)
        begin
            tok_next.created = 1'b1;
            tok_next.at      = ptil_slot_t'(IDX);
            tok_next.opt     = OPT_KEEP;
            tok_next.ent_vl  = tok_in.vlife;
            tok_next.ent_pl  = tok_in.plife;
        end
    end

    // Advance the token to the next slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Write the entry on append or update
    always_ff @(posedge clk)
    begin
        if (do_new)
        begin
            pfx_hi_reg <= tok_in.pfx_hi;
            pfx_lo_reg <= tok_in.pfx_lo;
            len_reg    <= tok_in.len;
            opt_reg    <= OPT_KEEP;
            vl_reg     <= tok_in.vlife;
            pl_reg     <= tok_in.plife;
        end
        else if (do_upd)
        begin
            opt_reg <= tok_in.flags;
            vl_reg  <= tok_in.vlife;
            pl_reg  <= tok_in.plife;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: src/prefix_table_insert_lookup_top.sv
// Top level of the prefix table: request register, chain of slot cells, result buffering.
// Depends on ptil_pkg and ptil_cell.
//
// A table of ENTRIES IPv6 prefixes, one per cell in a chain. An accepted
// request is masked to its length, then walks the chain one cell per cycle;
// the first occupied cell whose entry matches answers it, or the first free
// cell takes the new entry. One request is in the table at a time: a new
// request is not accepted until the last one has left the end of the cell
// chain, nor while the spare stage holds a result. A finished result is
// held in an output register plus one spare stage, so a request may be taken
// while an earlier result still waits. No clearing pass is needed after reset.
module prefix_table_insert_lookup_top #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] prefix_high,
    input  logic [63:0] prefix_low,
    input  logic [7:0]  prefix_length,
    input  logic [31:0] valid_lifetime,
    input  logic [31:0] preferred_lifetime,
    input  logic [7:0]  option_flags,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        created,
    output logic        table_full,
    output logic [3:0]  entry_index,
    output logic [7:0]  entry_options,
    output logic [31:0] entry_valid_lifetime,
    output logic [31:0] entry_preferred_lifetime
);
    import ptil_pkg::*;

    ptil_tok_t   tok_reg;
    ptil_tok_t   tok_next;
    ptil_tok_t   chain [0:ENTRIES];
    ptil_tok_t   fin;
    ptil_count_t count_reg;
    logic        busy_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    ptil_res_t   out_reg;
    ptil_res_t   skid_reg;
    ptil_res_t   res;

    logic                  accept;
    logic                  done;
    logic                  out_take;
    logic [7:0]            len_clamp;
    logic [PFX_BITS-1:0]   mask;

    assign accept   = in_valid && !in_stall;
    assign in_stall = busy_reg || skid_valid_reg;

    // Mask the request prefix to its length, capped at the full width
    always_comb
    begin
        len_clamp = (prefix_length > 8'(PFX_BITS)) ? 8'(PFX_BITS) : prefix_length;
        mask      = ~({PFX_BITS{1'b1}} >> len_clamp);
        tok_next  = '0;
        if (accept)
        begin
            tok_next.valid  = 1'b1;
            tok_next.req    = req_type;
            tok_next.pfx_hi = prefix_high & mask[PFX_BITS-1:64];
            tok_next.pfx_lo = prefix_low & mask[63:0];
            tok_next.len    = prefix_length;
            tok_next.vlife  = valid_lifetime;
            tok_next.plife  = preferred_lifetime;
            tok_next.flags  = option_flags;
        end
    end

    // Register the accepted request before it enters the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign chain[0] = tok_reg;

    // Chain of slot cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        ptil_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .count   (count_reg),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    assign fin  = chain[ENTRIES];
    assign done = fin.valid;

    // Form the result; fields stay zero when nothing was matched or created
    always_comb
    begin
        res         = '0;
        res.hit     = fin.found;
        res.created = fin.created;
        res.full    = (fin.req == REQ_ADD) && !fin.found && !fin.created;
        if (fin.found || fin.created)
        begin
            res.idx = fin.at[3:0];
            res.opt = fin.opt;
            res.vl  = fin.ent_vl;
            res.pl  = fin.ent_pl;
        end
    end

    // Track occupancy and the request in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            if (done)
            begin
                if (fin.req == REQ_CLEAR)
                begin
                    count_reg <= '0;
                end
                else if (fin.created)
                begin
                    count_reg <= ptil_count_t'(count_reg + 1'b1);
                end
            end
        end
    end

    assign out_take = out_valid_reg && !out_stall;

    // Output register with one spare stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= done;
                end
            end
            else if (done)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (done)
            begin
                out_reg <= res;
            end
        end
        else if (done)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid                = out_valid_reg;
    assign hit                      = out_reg.hit;
    assign created                  = out_reg.created;
    assign table_full               = out_reg.full;
    assign entry_index              = out_reg.idx;
    assign entry_options            = out_reg.opt;
    assign entry_valid_lifetime     = out_reg.vl;
    assign entry_preferred_lifetime = out_reg.pl;

endmodule

// File: src/ptil_checker.sv
// Port-level checks on the prefix table block, attached by bind below.
// Depends on prefix_table_insert_lookup_top_assert.svh.
module ptil_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  req_type,
    input logic [63:0] prefix_high,
    input logic [63:0] prefix_low,
    input logic [7:0]  prefix_length,
    input logic [31:0] valid_lifetime,
    input logic [31:0] preferred_lifetime,
    input logic [7:0]  option_flags,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic        created,
    input logic        table_full,
    input logic [3:0]  entry_index,
    input logic [7:0]  entry_options,
    input logic [31:0] entry_valid_lifetime,
    input logic [31:0] entry_preferred_lifetime
);
`include "prefix_table_insert_lookup_top_assert.svh"

    // a stalled result stays offered
    `PTIL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

    // at most one of hit, created and table_full
    `PTIL_ASSERT_NOW(a_one_outcome, out_valid, !(hit && created) && !(hit && table_full) && !(created && table_full), "conflicting outcome flags")

    // a new entry always starts with the keep option byte
    `PTIL_ASSERT_NOW(a_new_opt, out_valid && created, entry_options == 8'hff, "created entry without default options")

    // with no entry the slot fields read zero
    `PTIL_ASSERT_NOW(a_none_zero, out_valid && !hit && !created, entry_index == 4'd0 && entry_options == 8'd0 && entry_valid_lifetime == 32'd0 && entry_preferred_lifetime == 32'd0, "entry fields set without an entry")

endmodule

bind prefix_table_insert_lookup_top ptil_checker u_ptil_checker (.*);
